@@ hw/rtl/cwsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsa_pkg - shared types and constants for the clock with settable alarm
// Register indexes, reset values, time limits and the word types that pass
// between the time keeper, the alarm editor and the top level.
// ----------------------------------------------------------------------------
package cwsa_pkg;

    // Configuration register indexes
    localparam int          CFG_IDX_W          = 8;
    localparam logic [7:0]  CFG_TICKS_PER_SEC  = 8'd0;
    localparam logic [7:0]  CFG_BUTTON_REPEAT  = 8'd1;

    // Configuration reset values
    localparam logic [15:0] TICKS_PER_SEC_RST  = 16'd3000;
    localparam logic [15:0] BUTTON_REPEAT_RST  = 16'd800;

    // Time limits
    localparam logic [5:0]  SEC_MAX            = 6'd59;
    localparam logic [5:0]  MIN_MAX            = 6'd59;
    localparam logic [4:0]  HOUR_MAX           = 5'd23;

    // Clock reset time 23:59:35
    localparam logic [5:0]  SEC_RST            = 6'd35;
    localparam logic [5:0]  MIN_RST            = 6'd59;
    localparam logic [4:0]  HOUR_RST           = 5'd23;

    // Saved alarm reset values, outside every valid time
    localparam logic [5:0]  SAVED_MIN_RST      = 6'd63;
    localparam logic [4:0]  SAVED_HOUR_RST     = 5'd31;

    // Word widths
    localparam int          IN_DATA_W          = 8;
    localparam int          OUT_DATA_W         = 32;

    // Current time of day
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } clk_time_t;

    // Button and request levels of one tick
    typedef struct packed {
        logic stop_request;
        logic save_request;
        logic hour_down;
        logic hour_up;
        logic minute_down;
        logic minute_up;
    } btn_t;

    // Alarm editor status
    typedef struct packed {
        logic [4:0] edit_hour;
        logic [5:0] edit_minute;
        logic       armed;
        logic       led_on;
    } alarm_stat_t;

endpackage

@@ hw/rtl/cwsa_timekeep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsa_timekeep - prescaler and 24-hour time of day
// Counts ticks up to the configured limit, then steps the seconds, minutes
// and hours. Exposes the time after the current tick for the alarm match.
// ----------------------------------------------------------------------------
module cwsa_timekeep (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [15:0]          ticks_per_second,
    output cwsa_pkg::clk_time_t  time_next,
    output logic                 sec_hit
);
    import cwsa_pkg::*;

    logic [15:0] tick_count_reg;
    logic [15:0] tick_count_next;
    logic [16:0] tick_plus;
    clk_time_t   time_reg;
    clk_time_t   time_stepped;
    logic [5:0]  sec_inc;
    logic [5:0]  min_inc;
    logic [4:0]  hour_inc;

    // Prescaler: reaching or passing the limit fires and clears
    always_comb
    begin
        tick_plus = {1'b0, tick_count_reg} + 17'd1;
        sec_hit   = step && (tick_plus >= {1'b0, ticks_per_second});
        if (!step)
            tick_count_next = tick_count_reg;
        else if (sec_hit)
            tick_count_next = '0;
        else
            tick_count_next = tick_plus[15:0];
    end

    // One-second step with carries
    always_comb
    begin
        sec_inc  = time_reg.second + 6'd1;
        min_inc  = time_reg.minute + 6'd1;
        hour_inc = time_reg.hour + 5'd1;
        time_stepped = time_reg;
        if (time_reg.second >= SEC_MAX)
        begin
            time_stepped.second = '0;
            if (time_reg.minute >= MIN_MAX)
            begin
                time_stepped.minute = '0;
                time_stepped.hour   = (time_reg.hour >= HOUR_MAX) ? '0 : hour_inc;
            end
            else
            begin
                time_stepped.minute = min_inc;
            end
        end
        else
        begin
            time_stepped.second = sec_inc;
        end
        time_next = sec_hit ? time_stepped : time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            time_reg.second <= SEC_RST;
            time_reg.minute <= MIN_RST;
            time_reg.hour   <= HOUR_RST;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            time_reg       <= time_next;
        end
    end

    // Time stays a valid time of day
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg.second <= SEC_MAX && time_reg.minute <= MIN_MAX
        && time_reg.hour <= HOUR_MAX)
        else $error("time of day out of range");

    // Time moves only on a second step
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !sec_hit |=> $stable(time_reg))
        else $error("time changed without a second step");

endmodule

@@ hw/rtl/cwsa_alarm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsa_alarm - alarm setting, save, arm and LED
// Samples the buttons every repeat interval, steps the edited alarm with
// wrap at both ends, saves and arms it, and lights the LED on a match.
// ----------------------------------------------------------------------------
module cwsa_alarm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  cwsa_pkg::btn_t         btn,
    input  logic [15:0]            button_repeat_ticks,
    input  cwsa_pkg::clk_time_t    time_next,
    input  logic                   sec_hit,
    output cwsa_pkg::alarm_stat_t  stat_next
);
    import cwsa_pkg::*;

    logic [15:0] repeat_count_reg;
    logic [15:0] repeat_count_next;
    logic [16:0] repeat_plus;
    logic        btn_hit;
    logic [5:0]  edit_minute_reg;
    logic [4:0]  edit_hour_reg;
    logic [5:0]  saved_minute_reg;
    logic [4:0]  saved_hour_reg;
    logic        armed_reg;
    logic        led_reg;
    logic [5:0]  min_up;
    logic [5:0]  min_dn;
    logic [4:0]  hour_up;
    logic [4:0]  hour_dn;
    logic [5:0]  saved_minute_next;
    logic [4:0]  saved_hour_next;
    logic        match;

    // Button repeat counter
    always_comb
    begin
        repeat_plus = {1'b0, repeat_count_reg} + 17'd1;
        btn_hit     = step && (repeat_plus >= {1'b0, button_repeat_ticks});
        if (!step)
            repeat_count_next = repeat_count_reg;
        else if (btn_hit)
            repeat_count_next = '0;
        else
            repeat_count_next = repeat_plus[15:0];
    end

    // Edit steps (up first, then down), then match, save and stop
    always_comb
    begin
        min_up = edit_minute_reg;
        if (btn.minute_up)
            min_up = (edit_minute_reg >= MIN_MAX) ? '0 : edit_minute_reg + 6'd1;
        min_dn = min_up;
        if (btn.minute_down)
            min_dn = (min_up == '0 || min_up > MIN_MAX) ? MIN_MAX : min_up - 6'd1;

        hour_up = edit_hour_reg;
        if (btn.hour_up)
            hour_up = (edit_hour_reg >= HOUR_MAX) ? '0 : edit_hour_reg + 5'd1;
        hour_dn = hour_up;
        if (btn.hour_down)
            hour_dn = (hour_up == '0 || hour_up > HOUR_MAX) ? HOUR_MAX : hour_up - 5'd1;

        stat_next.edit_minute = btn_hit ? min_dn : edit_minute_reg;
        stat_next.edit_hour   = btn_hit ? hour_dn : edit_hour_reg;

        // Match, save, then stop
        match = sec_hit && armed_reg && saved_minute_reg == time_next.minute
                && saved_hour_reg == time_next.hour;
        saved_minute_next = saved_minute_reg;
        saved_hour_next   = saved_hour_reg;
        stat_next.armed   = armed_reg;
        stat_next.led_on  = led_reg || match;
        if (step && btn.save_request)
        begin
            saved_minute_next = stat_next.edit_minute;
            saved_hour_next   = stat_next.edit_hour;
            stat_next.armed   = 1'b1;
        end
        if (step && btn.stop_request)
        begin
            stat_next.armed  = 1'b0;
            stat_next.led_on = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg <= '0;
            edit_minute_reg  <= '0;
            edit_hour_reg    <= '0;
            saved_minute_reg <= SAVED_MIN_RST;
            saved_hour_reg   <= SAVED_HOUR_RST;
            armed_reg        <= 1'b0;
            led_reg          <= 1'b0;
        end
        else
        begin
            repeat_count_reg <= repeat_count_next;
            edit_minute_reg  <= stat_next.edit_minute;
            edit_hour_reg    <= stat_next.edit_hour;
            saved_minute_reg <= saved_minute_next;
            saved_hour_reg   <= saved_hour_next;
            armed_reg        <= stat_next.armed;
            led_reg          <= stat_next.led_on;
        end
    end

    // Edited alarm stays a valid time
    a_edit_range: assert property (@(posedge clk) disable iff (!rst_n)
        edit_minute_reg <= MIN_MAX && edit_hour_reg <= HOUR_MAX)
        else $error("edited alarm out of range");

    // LED lights only from an armed alarm
    a_led_armed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(led_reg) |-> $past(armed_reg))
        else $error("LED lit while disarmed");

endmodule

@@ hw/rtl/clock_with_settable_alarm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_with_settable_alarm - 24-hour clock with a button-set alarm
// One input word is one timer tick with button levels; one output word is
// the time, the edited alarm, the armed flag and the LED after that tick.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  s_*      in         s_tvalid / s_tready    s_tdata[7:0]   one tick
//  m_*      out        m_tvalid / m_tready    m_tdata[31:0]  status word
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One word per cycle while the output is not stalled: input register,
//  then result register, with all state updated in the step between them.
//  Reset gives 23:59:35, alarm 00:00, disarmed, LED off.
//  A stalled output holds the result; the input register still takes one
//  more word, then s_tready drops until m_tready returns.
//  Configuration writes are taken in any cycle (cfg_ready is always high).
// ----------------------------------------------------------------------------
module clock_with_settable_alarm (
    input  logic                             clk,
    input  logic                             rst_n,
    // minute_up, minute_down, hour_up, hour_down, save_request,
    // stop_request, 2'b0 (from bit 0)
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cwsa_pkg::IN_DATA_W-1:0]   s_tdata,
    // second_now[5:0], minute_now[11:6], hour_now[16:12],
    // alarm_minute_shown[22:17], alarm_hour_shown[27:23], armed[28],
    // led_on[29], 2'b0
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cwsa_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cwsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                      cfg_data
);
    import cwsa_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    btn_t        btn_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [15:0] ticks_per_sec_reg;
    logic [15:0] button_repeat_reg;
    logic        advance;
    logic        step;
    logic        s_fire;
    clk_time_t   time_next;
    logic        sec_hit;
    alarm_stat_t stat_next;

    // Handshake and pipeline advance
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign step      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
        out_data_next  = {2'b00, stat_next.led_on, stat_next.armed,
                          stat_next.edit_hour, stat_next.edit_minute,
                          time_next.hour, time_next.minute, time_next.second};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            ticks_per_sec_reg <= TICKS_PER_SEC_RST;
            button_repeat_reg <= BUTTON_REPEAT_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TICKS_PER_SEC: ticks_per_sec_reg <= cfg_data;
                    CFG_BUTTON_REPEAT: button_repeat_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
            btn_reg <= btn_t'(s_tdata[5:0]);
        if (step)
            out_data_reg <= out_data_next;
    end

    cwsa_timekeep u_timekeep (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .ticks_per_second (ticks_per_sec_reg),
        .time_next        (time_next),
        .sec_hit          (sec_hit)
    );

    cwsa_alarm u_alarm (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (step),
        .btn                 (btn_reg),
        .button_repeat_ticks (button_repeat_reg),
        .time_next           (time_next),
        .sec_hit             (sec_hit),
        .stat_next           (stat_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Input side stalls only with both stages full and the output held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    // A new result comes only from a held input word
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without an input word");

endmodule

@@ tb/clock_with_settable_alarm_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_with_settable_alarm_tb - self-checking bench for the alarm clock
// Drives one tick word per handshake and keeps its own model of the prescaler,
// the time of day, the alarm editor and the saved alarm. It predicts every
// status word and checks it field by field in arrival order. A short directed
// table covers the button wraps, save/stop and the day rollover into an alarm
// hit. Random phases follow: noise words under several prescaler settings,
// and alarm hunts that walk the edited alarm onto the running time, save it,
// wait for the LED and stop it. Both sides stall at random, with one long
// output hold that backs the block up.
// ----------------------------------------------------------------------------
module clock_with_settable_alarm_tb;

    import cwsa_pkg::*;

    localparam btn_t B_NONE = 6'b000000;
    localparam btn_t B_MU   = 6'b000001;
    localparam btn_t B_MD   = 6'b000010;
    localparam btn_t B_HU   = 6'b000100;
    localparam btn_t B_HD   = 6'b001000;
    localparam btn_t B_SAVE = 6'b010000;
    localparam btn_t B_STOP = 6'b100000;

    localparam int LONG_HOLD_CYCLES = 200;

    // Output word, laid out as on m_tdata
    typedef struct packed {
        logic [1:0] pad;
        logic       led;
        logic       armed;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_min;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } status_word_t;

    typedef enum logic { ROW_CFG, ROW_TICK } row_kind_t;
    typedef enum logic { HUNT_WALK, HUNT_WAIT } hunt_stage_t;

    typedef struct {
        row_kind_t    kind;
        logic [7:0]   reg_idx;
        logic [15:0]  reg_val;
        btn_t         btns;
        bit           typed;
        status_word_t want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [15:0]            cfg_data;

    // Model state
    logic [15:0] tps_cfg;
    logic [15:0] rpt_cfg;
    logic [15:0] tick_div;
    logic [15:0] btn_div;
    logic [5:0]  clk_sec;
    logic [5:0]  clk_min;
    logic [4:0]  clk_hr;
    logic [5:0]  set_min;
    logic [4:0]  set_hr;
    logic [5:0]  alarm_min;
    logic [4:0]  alarm_hr;
    bit          alarm_armed;
    bit          alarm_led;

    status_word_t pending_status[$];
    stim_row_t    dir_rows[$];
    int           errors;
    int           words_seen;
    bit           quiet;
    bit           hold_req;

    clock_with_settable_alarm DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("clock_with_settable_alarm_tb: done, errors");
        $finish;
    end

    function automatic status_word_t mk_status(input int sec, input int min, input int hr,
                                               input int amin, input int ahr,
                                               input bit arm, input bit led);
        status_word_t w;
        w            = '0;
        w.second     = 6'(sec);
        w.minute     = 6'(min);
        w.hour       = 5'(hr);
        w.alarm_min  = 6'(amin);
        w.alarm_hour = 5'(ahr);
        w.armed      = arm;
        w.led        = led;
        return w;
    endfunction

    function automatic stim_row_t cfg_row(input logic [7:0] idx, input logic [15:0] val);
        return stim_row_t'{ROW_CFG, idx, val, B_NONE, 1'b0, '0};
    endfunction

    function automatic stim_row_t tick_row(input btn_t b);
        return stim_row_t'{ROW_TICK, '0, '0, b, 1'b0, '0};
    endfunction

    function automatic stim_row_t check_row(input btn_t b, input status_word_t w);
        return stim_row_t'{ROW_TICK, '0, '0, b, 1'b1, w};
    endfunction

    // One tick of the clock: prescaler, time step, alarm match, button sample, save, stop
    task automatic advance_clock(input btn_t b, output status_word_t w);
        bit sec_hit;
        bit btn_hit;
        sec_hit  = ({1'b0, tick_div} + 17'd1) >= {1'b0, tps_cfg};
        tick_div = sec_hit ? 16'd0 : tick_div + 16'd1;
        if (sec_hit)
        begin
            clk_sec = clk_sec + 6'd1;
            if (clk_sec >= 6'd60)
            begin
                clk_sec = 6'd0;
                clk_min = clk_min + 6'd1;
            end
            if (clk_min >= 6'd60)
            begin
                clk_min = 6'd0;
                clk_hr  = clk_hr + 5'd1;
            end
            if (clk_hr >= 5'd24)
                clk_hr = 5'd0;
            if (alarm_armed && alarm_min == clk_min && alarm_hr == clk_hr)
                alarm_led = 1'b1;
        end

        btn_hit = ({1'b0, btn_div} + 17'd1) >= {1'b0, rpt_cfg};
        btn_div = btn_hit ? 16'd0 : btn_div + 16'd1;
        if (btn_hit)
        begin
            // up first, then down; both wrap
            if (b.minute_up)
                set_min = (set_min >= MIN_MAX) ? 6'd0 : set_min + 6'd1;
            if (b.minute_down)
                set_min = (set_min == 6'd0 || set_min > MIN_MAX) ? MIN_MAX : set_min - 6'd1;
            if (b.hour_up)
                set_hr = (set_hr >= HOUR_MAX) ? 5'd0 : set_hr + 5'd1;
            if (b.hour_down)
                set_hr = (set_hr == 5'd0 || set_hr > HOUR_MAX) ? HOUR_MAX : set_hr - 5'd1;
        end

        if (b.save_request)
        begin
            alarm_min   = set_min;
            alarm_hr    = set_hr;
            alarm_armed = 1'b1;
        end
        if (b.stop_request)
        begin
            alarm_led   = 1'b0;
            alarm_armed = 1'b0;
        end

        w = mk_status(clk_sec, clk_min, clk_hr, set_min, set_hr, alarm_armed, alarm_led);
    endtask

    // Offer one tick word, wait for it to be taken, queue its status
    task automatic send_tick(input btn_t b, input bit typed, input status_word_t want);
        status_word_t w;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(b);
        do @(posedge clk); while (!s_tready);
        advance_clock(b, w);
        pending_status.push_back(typed ? want : w);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Drain all outstanding words, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TICKS_PER_SEC)
            tps_cfg = val;
        else if (idx == CFG_BUTTON_REPEAT)
            rpt_cfg = val;
    endtask

    task automatic noise_phase(input int n);
        repeat (n)
            send_tick(btn_t'($urandom_range(0, 63)), 1'b0, '0);
    endtask

    // Walk the edited alarm onto the running time, save, wait for the LED, stop
    task automatic hunt_phase(input int n);
        hunt_stage_t stage;
        int          lead;
        int          waited;
        int          tgt_min;
        int          tgt_hr;
        int          gap;
        btn_t        b;
        stage = HUNT_WALK;
        lead  = $urandom_range(0, 1);
        waited = 0;
        repeat (n)
        begin
            b = B_NONE;
            tgt_min = int'(clk_min) + lead;
            tgt_hr  = int'(clk_hr);
            if (tgt_min >= 60)
            begin
                tgt_min = tgt_min - 60;
                tgt_hr  = (tgt_hr + 1) % 24;
            end
            if ($urandom_range(0, 5) == 0)
                b = btn_t'($urandom_range(0, 63));
            else if (stage == HUNT_WALK)
            begin
                gap = (tgt_min - int'(set_min) + 60) % 60;
                if (gap != 0)
                begin
                    if (gap <= 30)
                        b.minute_up = 1'b1;
                    else
                        b.minute_down = 1'b1;
                end
                gap = (tgt_hr - int'(set_hr) + 24) % 24;
                if (gap != 0)
                begin
                    if (gap <= 12)
                        b.hour_up = 1'b1;
                    else
                        b.hour_down = 1'b1;
                end
                if (b == B_NONE)
                begin
                    b.save_request = 1'b1;
                    // now and then save and stop together: ends disarmed
                    if ($urandom_range(0, 5) == 0)
                        b.stop_request = 1'b1;
                    else
                    begin
                        stage  = HUNT_WAIT;
                        waited = 0;
                    end
                end
            end
            else
            begin
                waited++;
                if (alarm_led || waited > 70 * (int'(tps_cfg) + 1))
                begin
                    b.stop_request = 1'b1;
                    stage = HUNT_WALK;
                    lead  = $urandom_range(0, 1);
                end
                else if ($urandom_range(0, 3) == 0)
                    b = btn_t'($urandom_range(0, 15));
            end
            send_tick(b, 1'b0, '0);
        end
    endtask

    task automatic note_error(input string what);
        errors++;
        if (errors <= 10)
            $display("%0t: word %0d: %s", $time, words_seen, what);
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
            note_error($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    task automatic check_status(input status_word_t got);
        status_word_t want;
        words_seen++;
        if (pending_status.size() == 0)
        begin
            note_error($sformatf("unexpected word %h", got));
            return;
        end
        want = pending_status.pop_front();
        cmp_field("second_now",         want.second,     got.second);
        cmp_field("minute_now",         want.minute,     got.minute);
        cmp_field("hour_now",           want.hour,       got.hour);
        cmp_field("alarm_minute_shown", want.alarm_min,  got.alarm_min);
        cmp_field("alarm_hour_shown",   want.alarm_hour, got.alarm_hour);
        cmp_field("armed",              want.armed,      got.armed);
        cmp_field("led_on",             want.led,        got.led);
        cmp_field("padding",            want.pad,        got.pad);
    endtask

    // Output side: check taken words, random stalls, one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_status(status_word_t'(m_tdata));
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        errors     = 0;
        words_seen = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;

        tps_cfg     = TICKS_PER_SEC_RST;
        rpt_cfg     = BUTTON_REPEAT_RST;
        tick_div    = '0;
        btn_div     = '0;
        clk_sec     = SEC_RST;
        clk_min     = MIN_RST;
        clk_hr      = HOUR_RST;
        set_min     = '0;
        set_hr      = '0;
        alarm_min   = SAVED_MIN_RST;
        alarm_hr    = SAVED_HOUR_RST;
        alarm_armed = 1'b0;
        alarm_led   = 1'b0;

        // Directed table: zero intervals act as one, so every tick is a
        // second and a button sample, starting from 23:59:35
        dir_rows.push_back(cfg_row(CFG_TICKS_PER_SEC, 16'd0));
        dir_rows.push_back(cfg_row(CFG_BUTTON_REPEAT, 16'd0));
        // decrement at zero, increment at the top
        dir_rows.push_back(check_row(B_MD, mk_status(36, 59, 23, 59, 0, 0, 0)));
        dir_rows.push_back(check_row(B_HD, mk_status(37, 59, 23, 59, 23, 0, 0)));
        dir_rows.push_back(check_row(B_MU, mk_status(38, 59, 23, 0, 23, 0, 0)));
        dir_rows.push_back(check_row(B_HU, mk_status(39, 59, 23, 0, 0, 0, 0)));
        // opposite buttons cancel, save with stop ends disarmed
        dir_rows.push_back(check_row(B_MU | B_MD | B_HU | B_HD,
                                     mk_status(40, 59, 23, 0, 0, 0, 0)));
        dir_rows.push_back(check_row(B_SAVE | B_STOP, mk_status(41, 59, 23, 0, 0, 0, 0)));
        dir_rows.push_back(check_row(B_SAVE, mk_status(42, 59, 23, 0, 0, 1, 0)));
        // editing after save leaves the saved 00:00 alone
        dir_rows.push_back(tick_row(B_MU | B_HU));
        repeat (16)
            dir_rows.push_back(tick_row(B_NONE));
        // midnight rollover hits the saved alarm
        dir_rows.push_back(check_row(B_NONE, mk_status(0, 0, 0, 1, 1, 1, 1)));
        dir_rows.push_back(check_row(B_STOP, mk_status(1, 0, 0, 1, 1, 0, 0)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
                send_tick(dir_rows[i].btns, dir_rows[i].typed, dir_rows[i].want);
        end

        // Widest intervals, with a long output hold to back the block up
        write_reg(CFG_TICKS_PER_SEC, 16'hFFFF);
        write_reg(CFG_BUTTON_REPEAT, 16'hFFFF);
        hold_req = 1'b1;
        noise_phase(120);

        // Intervals dropped below the running counts
        write_reg(CFG_TICKS_PER_SEC, 16'd1);
        write_reg(CFG_BUTTON_REPEAT, 16'd1);
        hunt_phase(400);

        write_reg(CFG_TICKS_PER_SEC, 16'($urandom_range(2, 5)));
        write_reg(CFG_BUTTON_REPEAT, 16'($urandom_range(1, 4)));
        noise_phase(150);

        write_reg(CFG_TICKS_PER_SEC, 16'd2);
        write_reg(CFG_BUTTON_REPEAT, 16'd3);
        hunt_phase(350);

        write_reg(CFG_TICKS_PER_SEC, 16'($urandom_range(0, 65535)));
        write_reg(CFG_BUTTON_REPEAT, 16'($urandom_range(0, 65535)));
        noise_phase(100);

        // Last stretch runs without idling on either side
        write_reg(CFG_TICKS_PER_SEC, 16'd1);
        write_reg(CFG_BUTTON_REPEAT, 16'd2);
        quiet = 1'b1;
        hunt_phase(230);

        wait_idle();
        if (errors == 0)
            $display("clock_with_settable_alarm_tb: done, clean");
        else
            $display("clock_with_settable_alarm_tb: done, errors");
        $finish;
    end

endmodule
